>>> rtl/bdm_pkg.sv
// shared types, constants and helper functions for the bilinear duty map
package bdm_pkg;

    localparam int TEMP_MIN    = 10;
    localparam int TEMP_MAX    = 30;
    localparam int HR_MIN      = 105;
    localparam int HR_MAX      = 145;
    localparam int GRID_STEP   = 5;
    localparam int DUTY_LIMIT  = 100;
    localparam int DEF_ROWS    = 5;
    localparam int DEF_COLS    = 9;

    // floor(x / 5) for x < 1024 and floor(x / 25) for x < 6400
    localparam int DIV5_MUL    = 205;
    localparam int DIV5_SHIFT  = 10;
    localparam int DIV25_MUL   = 5243;
    localparam int DIV25_SHIFT = 17;

    localparam logic [1:0] CMD_QUERY   = 2'd0;
    localparam logic [1:0] CMD_WRITE   = 2'd1;
    localparam logic [1:0] CMD_RESTORE = 2'd2;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_INDEX = 1'b1;

    localparam logic [7:0] DEFAULT_MAP [DEF_ROWS][DEF_COLS] = '{
        '{8'd0, 8'd0,  8'd1,  8'd5,  8'd10, 8'd20, 8'd35,  8'd70,  8'd80},
        '{8'd0, 8'd0,  8'd2,  8'd5,  8'd12, 8'd40, 8'd60,  8'd80,  8'd100},
        '{8'd0, 8'd1,  8'd5,  8'd12, 8'd20, 8'd42, 8'd65,  8'd85,  8'd100},
        '{8'd0, 8'd5,  8'd20, 8'd30, 8'd45, 8'd65, 8'd85,  8'd100, 8'd100},
        '{8'd0, 8'd10, 8'd25, 8'd45, 8'd65, 8'd85, 8'd100, 8'd100, 8'd100}
    };

    // position of one axis value on its grid
    typedef struct packed {
        logic [3:0] lo;
        logic [3:0] hi;
        logic [2:0] w;
    } loc_t;

    // table port request from the sequencer
    typedef struct packed {
        logic       wr_en;
        logic       clr;
        logic [3:0] wr_row;
        logic [3:0] wr_col;
        logic [7:0] wr_data;
        logic       rd_en;
        logic [3:0] rd_row;
        logic [3:0] rd_col;
    } tbl_req_t;

    function automatic logic [7:0] default_entry(input logic [3:0] row,
                                                 input logic [3:0] col);
        logic [7:0] val;
        val = 8'd0;
        if (row < 4'(DEF_ROWS) && col < 4'(DEF_COLS))
        begin
            val = DEFAULT_MAP[row[2:0]][col];
        end
        return val;
    endfunction

    function automatic loc_t locate(input logic [7:0] value,
                                    input logic [7:0] lo_val,
                                    input logic [4:0] points);
        logic [7:0]  off;
        logic [15:0] prod;
        logic [5:0]  q;
        logic [7:0]  r8;
        loc_t        res;
        off  = value - lo_val;
        prod = 16'(off) * 16'(DIV5_MUL);
        q    = 6'(prod >> DIV5_SHIFT);
        r8   = off - 8'(q) * 8'(GRID_STEP);
        res  = '0;
        if (value < lo_val)
        begin
            res = '0;
        end
        else if (q >= 6'(points) - 6'd1)
        begin
            res.lo = 4'(points - 5'd1);
            res.hi = 4'(points - 5'd1);
            res.w  = 3'd0;
        end
        else
        begin
            res.lo = q[3:0];
            res.hi = (r8 != 8'd0) ? q[3:0] + 4'd1 : q[3:0];
            res.w  = r8[2:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/bdm_table.sv
// duty table memory with per-entry valid bits that fall back to the default map
module bdm_table #(
    parameter int TEMP_POINTS = 5,
    parameter int HR_POINTS   = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bdm_pkg::tbl_req_t req,
    output logic [7:0]        rd_data
);

    localparam int DEPTH = TEMP_POINTS * HR_POINTS;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0]       table_mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       mem_q_reg;
    logic [7:0]       dflt_reg;
    logic             vld_q_reg;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;

    assign wr_addr = AW'(req.wr_row) * AW'(HR_POINTS) + AW'(req.wr_col);
    assign rd_addr = AW'(req.rd_row) * AW'(HR_POINTS) + AW'(req.rd_col);

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            table_mem[wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            mem_q_reg <= table_mem[rd_addr];
            dflt_reg  <= bdm_pkg::default_entry(req.rd_row, req.rd_col);
        end
    end

    // an entry not written since reset or restore reads as its default
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (req.clr)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                vld_q_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = vld_q_reg ? mem_q_reg : dflt_reg;

endmodule

>>> rtl/bdm_ctrl.sv
// command decode and query sequencer: four table reads, weighted sum, divide by 25
module bdm_ctrl #(
    parameter int TEMP_POINTS = 5,
    parameter int HR_POINTS   = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        command,
    input  logic [7:0]        heart_rate,
    input  logic [7:0]        temperature,
    input  logic [2:0]        row_index,
    input  logic [3:0]        column_index,
    input  logic [7:0]        entry_value,
    input  logic [7:0]        rd_data,
    output bdm_pkg::tbl_req_t req,
    output logic              busy,
    output logic              done,
    output logic [6:0]        duty_percent,
    output logic              status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LAST,
        S_DIV
    } state_t;

    state_t        state_reg, state_next;
    logic [1:0]    cnt_reg, cnt_next;
    bdm_pkg::loc_t tloc_reg, tloc_next;
    bdm_pkg::loc_t hloc_reg, hloc_next;
    logic [12:0]   acc_reg, acc_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [4:0]    wt_reg, wt_next;
    logic          done_reg, done_next;
    logic [6:0]    duty_reg, duty_next;
    logic          status_reg, status_next;

    logic          accept;
    logic          idx_ok;
    logic [2:0]    t_wt;
    logic [2:0]    h_wt;
    logic [25:0]   quot_prod;
    logic [8:0]    quot;

    assign accept = start && (state_reg == S_IDLE);
    assign idx_ok = (5'(row_index) < 5'(TEMP_POINTS)) && (5'(column_index) < 5'(HR_POINTS));

    // weight of the entry read this cycle: low or high point on each axis
    assign t_wt = cnt_reg[1] ? tloc_reg.w : 3'(bdm_pkg::GRID_STEP) - tloc_reg.w;
    assign h_wt = cnt_reg[0] ? hloc_reg.w : 3'(bdm_pkg::GRID_STEP) - hloc_reg.w;

    assign quot_prod = 26'(acc_reg) * 26'(bdm_pkg::DIV25_MUL);
    assign quot      = 9'(quot_prod >> bdm_pkg::DIV25_SHIFT);

    always_comb
    begin
        req         = '0;
        req.wr_row  = 4'(row_index);
        req.wr_col  = column_index;
        req.wr_data = entry_value;
        req.rd_en   = (state_reg == S_READ);
        req.rd_row  = cnt_reg[1] ? tloc_reg.hi : tloc_reg.lo;
        req.rd_col  = cnt_reg[0] ? hloc_reg.hi : hloc_reg.lo;
        if (accept && command == bdm_pkg::CMD_WRITE && idx_ok)
        begin
            req.wr_en = 1'b1;
        end
        if (accept && command == bdm_pkg::CMD_RESTORE)
        begin
            req.clr = 1'b1;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        tloc_next    = tloc_reg;
        hloc_next    = hloc_reg;
        acc_next     = acc_reg;
        rd_pend_next = (state_reg == S_READ);
        wt_next      = 5'(t_wt) * 5'(h_wt);
        done_next    = 1'b0;
        duty_next    = duty_reg;
        status_next  = status_reg;

        if (rd_pend_reg)
        begin
            acc_next = acc_reg + 13'(rd_data) * 13'(wt_reg);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (command == bdm_pkg::CMD_QUERY)
                    begin
                        tloc_next  = bdm_pkg::locate(temperature, 8'(bdm_pkg::TEMP_MIN),
                                                     5'(TEMP_POINTS));
                        hloc_next  = bdm_pkg::locate(heart_rate, 8'(bdm_pkg::HR_MIN),
                                                     5'(HR_POINTS));
                        acc_next   = '0;
                        cnt_next   = 2'd0;
                        state_next = S_READ;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        duty_next   = 7'd0;
                        status_next = (command == bdm_pkg::CMD_WRITE && !idx_ok)
                                      ? bdm_pkg::STATUS_BAD_INDEX : bdm_pkg::STATUS_OK;
                    end
                end
            end
            S_READ:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                done_next   = 1'b1;
                duty_next   = (quot > 9'(bdm_pkg::DUTY_LIMIT)) ? 7'(bdm_pkg::DUTY_LIMIT)
                                                               : quot[6:0];
                status_next = bdm_pkg::STATUS_OK;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= 2'd0;
            rd_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
            tloc_reg    <= '0;
            hloc_reg    <= '0;
            acc_reg     <= '0;
            wt_reg      <= '0;
            duty_reg    <= '0;
            status_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_pend_reg <= rd_pend_next;
            done_reg    <= done_next;
            tloc_reg    <= tloc_next;
            hloc_reg    <= hloc_next;
            acc_reg     <= acc_next;
            wt_reg      <= wt_next;
            duty_reg    <= duty_next;
            status_reg  <= status_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign duty_percent = duty_reg;
    assign status       = status_reg;

endmodule

>>> rtl/bilinear_duty_map.sv
// query: busy rises after the accepting edge and stays high through the read, last and divide
// states, and done strobes as busy falls; write, restore and unused commands: done strobes the
// next cycle, busy stays low; no new query is taken until the last ends: four reads through
// the single table read port plus the last accumulate, divide and return to idle
// one write or restore per cycle if idle; reset is asynchronous: all valid bits clear, so the
// table reads as the default map at once; restore clears all valid bits together; the receiver cannot stall a result
module bilinear_duty_map #(
    parameter int TEMP_POINTS = 5,
    parameter int HR_POINTS   = 9
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] command,
    input  logic [7:0] heart_rate,
    input  logic [7:0] temperature,
    input  logic [2:0] row_index,
    input  logic [3:0] column_index,
    input  logic [7:0] entry_value,
    output logic       done,
    output logic [6:0] duty_percent,
    output logic       status
);

    bdm_pkg::tbl_req_t req;
    logic [7:0]        rd_data;

    bdm_ctrl #(
        .TEMP_POINTS(TEMP_POINTS),
        .HR_POINTS  (HR_POINTS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .command     (command),
        .heart_rate  (heart_rate),
        .temperature (temperature),
        .row_index   (row_index),
        .column_index(column_index),
        .entry_value (entry_value),
        .rd_data     (rd_data),
        .req         (req),
        .busy        (busy),
        .done        (done),
        .duty_percent(duty_percent),
        .status      (status)
    );

    bdm_table #(
        .TEMP_POINTS(TEMP_POINTS),
        .HR_POINTS  (HR_POINTS)
    ) u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rd_data(rd_data)
    );

endmodule

>>> rtl/bdm_checker.sv
// port-level checks for the bilinear duty map, bound to the top level
module bdm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] command,
    input logic       done,
    input logic [6:0] duty_percent,
    input logic       status
);

    // a result never exceeds the duty limit
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> duty_percent <= 7'(bdm_pkg::DUTY_LIMIT))
        else $error("duty above limit");

    // a dropped write reports zero duty
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == bdm_pkg::STATUS_BAD_INDEX) |-> duty_percent == 7'd0)
        else $error("dropped write with nonzero duty");

    // a non-query transaction completes in the next cycle without going busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command != bdm_pkg::CMD_QUERY) |=> (done && !busy))
        else $error("non-query transaction not completed next cycle");

    // a query keeps the block busy and produces no result right away
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == bdm_pkg::CMD_QUERY) |=> (busy && !done))
        else $error("query did not enter busy");

endmodule

bind bilinear_duty_map bdm_checker u_bdm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .done        (done),
    .duty_percent(duty_percent),
    .status      (status)
);
